>>> sv/smd_pkg.sv
package smd_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIDTH     = 3'd0;
  localparam logic [2:0] CFG_HEIGHT    = 3'd1;
  localparam logic [2:0] CFG_MARGIN    = 3'd2;
  localparam logic [2:0] CFG_ROW_LIMIT = 3'd3;

  // Reset values of the configuration registers.
  localparam logic [10:0] RST_WIDTH     = 11'd1024;
  localparam logic [15:0] RST_HEIGHT    = 16'd1024;
  localparam logic [3:0]  RST_MARGIN    = 4'd1;
  localparam logic [15:0] RST_ROW_LIMIT = 16'd0;

  // Control that every vertical cell sees.
  typedef struct packed {
    logic adv;    // a request is taken this cycle
    logic rd_ok;  // the row above the current one lies in this frame
  } smd_vctl_t;

  // Label merge: empty yields the other side, equal labels stay, and
  // differing labels give all ones (the conflict label). Callers pass
  // zero-extended labels and keep the low bits of the result.
  function automatic logic [31:0] smd_merge(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    if (a == 32'd0) begin
      r = b;
    end else if (b == 32'd0 || a == b) begin
      r = a;
    end else begin
      r = '1;
    end
    return r;
  endfunction

endpackage

>>> sv/smd_hcell.sv
module smd_hcell import smd_pkg::*; #(
  parameter int LB = 17
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [LB-1:0] pin,
  input  logic [LB-1:0] src,
  output logic [LB-1:0] pout
);

  logic [LB-1:0] pout_next;

  // Each cell widens the run of merged sources by one pixel.
  assign pout_next = LB'(smd_merge(32'(pin), 32'(src)));

  always_ff @(posedge clk) begin
    if (adv) begin
      pout <= pout_next;
    end
  end

endmodule

>>> sv/smd_vcell.sv
module smd_vcell import smd_pkg::*; #(
  parameter int LB    = 17,
  parameter int DEPTH = 1023,
  parameter int AB    = 10
) (
  input  logic          clk,
  input  smd_vctl_t     vctl,
  input  logic [AB-1:0] ptr,
  input  logic [LB-1:0] vin,
  input  logic [LB-1:0] hm,
  output logic [LB-1:0] vout
);

  logic [LB-1:0] mem [0:DEPTH-1];
  logic [LB-1:0] rd;
  logic [LB-1:0] rd_m;

  // One row of delay: read the old entry, then store the new one.
  always_ff @(posedge clk) begin
    if (vctl.adv) begin
      rd       <= mem[ptr];
      mem[ptr] <= vin;
    end
  end

  // Merge the current row with the run of rows above it.
  assign rd_m = vctl.rd_ok ? rd : '0;
  assign vout = LB'(smd_merge(32'(hm), 32'(rd_m)));

endmodule

>>> sv/segment_mask_dilation.sv
// Label dilation with conflict marking over a raster-order mask stream. One
// pixel is taken per cycle and a result leaves per cycle when not stalled; the
// result for pixel p is registered at the edge that takes the request of pixel
// p + margin*width + margin and is offered from the next cycle, so the host
// appends that many padding pixels after each frame. A row of 2*MAX_MARGIN
// register cells merges the window along a row, and 2*MAX_MARGIN cells, each
// with a one-row line memory of MAX_WIDTH-1 entries read once and written once
// per pixel, merge down the columns; the merge through both chains is
// combinational, which sets the one-pixel-per-cycle rate. Line memories need
// no clearing pass since only rows of the current frame are read. Margin 0
// passes pixels straight through, delayed only by the output register.
module segment_mask_dilation import smd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_MARGIN = 8,
  parameter int LABEL_BITS = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [LABEL_BITS-1:0] label,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [LABEL_BITS-1:0] out_label,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);

  localparam int LB    = LABEL_BITS;
  localparam int NC    = 2 * MAX_MARGIN;
  localparam int HB    = $clog2(NC);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int MB    = $clog2(MAX_MARGIN + 1);
  localparam int RB    = 17;
  localparam int NB    = $clog2(MAX_MARGIN * MAX_WIDTH + MAX_MARGIN + 1);
  localparam int PB    = $clog2(MAX_WIDTH * 65536);
  localparam int DEPTH = MAX_WIDTH - 1;
  localparam int AB    = $clog2(MAX_WIDTH - 1);

  logic [10:0] image_width;
  logic [15:0] image_height;
  logic [3:0]  margin;
  logic [15:0] row_limit;

  logic [WB-1:0] wc;
  logic [15:0]   hc;
  logic [15:0]   eh;
  logic [MB-1:0] mc;
  logic [NB-1:0] lag;
  logic [PB-1:0] total;

  logic [NB-1:0] ncnt;
  logic [WB-1:0] icol;
  logic [RB-1:0] irow;
  logic [WB-1:0] qcol;
  logic [RB-1:0] qrow;
  logic [PB-1:0] pcnt;
  logic [AB-1:0] ptr;
  logic [AB-1:0] ptr_next;

  logic          adv;
  logic          cfg_wr;
  logic          inframe;
  logic          colok;
  logic          qv;
  logic          rowok;
  logic          ov;
  logic          nosrc;
  logic          last_v;
  logic          restart;
  logic [HB-1:0] sel;
  logic [LB-1:0] lab;
  logic [LB-1:0] src;
  logic [LB-1:0] hsum;
  logic [LB-1:0] hm;
  logic [LB-1:0] res;
  smd_vctl_t     vctl;

  logic [LB-1:0] pcell [0:NC-1];
  logic [LB-1:0] pin   [0:NC-1];
  logic [LB-1:0] vin   [0:NC-1];
  logic [LB-1:0] vout  [0:NC-1];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign adv       = in_valid && !in_stall;
  assign lab       = label;

  // Configuration registers.
  always_comb begin
    cfg_wr = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH, CFG_HEIGHT, CFG_MARGIN, CFG_ROW_LIMIT: cfg_wr = 1'b1;
        default: cfg_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      margin       <= RST_MARGIN;
      row_limit    <= RST_ROW_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH:     image_width  <= cfg_data[10:0];
        CFG_HEIGHT:    image_height <= cfg_data;
        CFG_MARGIN:    margin       <= cfg_data[3:0];
        CFG_ROW_LIMIT: row_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry after clamping.
  always_comb begin
    if (image_width == 11'd0) begin
      wc = WB'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      wc = WB'(MAX_WIDTH);
    end else begin
      wc = WB'(image_width);
    end
    hc = (image_height == 16'd0) ? 16'd1 : image_height;
    eh = (row_limit != 16'd0 && row_limit < hc) ? row_limit : hc;
    mc = (32'(margin) > 32'(MAX_MARGIN)) ? MB'(MAX_MARGIN) : MB'(margin);
  end

  assign lag   = NB'(32'(mc) * 32'(wc) + 32'(mc));
  assign total = PB'(32'(wc) * 32'(hc));
  assign nosrc = (32'(mc) * 32'd2 + 32'd1) > 32'(wc);
  assign sel   = HB'(32'(mc) * 32'd2 - 32'd1);

  // Position of the incoming pixel, of the window center and of the result.
  assign inframe = 32'(irow) < 32'(hc);
  assign colok   = (32'(icol) >= 32'(mc)) && (32'(icol) + 32'(mc) + 32'd1 <= 32'(wc));
  assign qv      = 32'(ncnt) >= 32'(mc);
  assign rowok   = qv && (32'(qrow) >= 32'(mc))
                   && (32'(qrow) + 32'(mc) + 32'd1 <= 32'(eh));
  assign ov      = ncnt >= lag;
  assign last_v  = pcnt == total - PB'(1);
  assign restart = cfg_wr || (adv && ov && last_v);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ncnt <= '0;
      icol <= '0;
      irow <= '0;
      qcol <= '0;
      qrow <= '0;
      pcnt <= '0;
    end else if (adv) begin
      if (ncnt < lag) begin
        ncnt <= ncnt + NB'(1);
      end
      if (32'(icol) + 32'd1 >= 32'(wc)) begin
        icol <= '0;
        irow <= irow + RB'(1);
      end else begin
        icol <= icol + WB'(1);
      end
      if (qv) begin
        if (32'(qcol) + 32'd1 >= 32'(wc)) begin
          qcol <= '0;
          qrow <= qrow + RB'(1);
        end else begin
          qcol <= qcol + WB'(1);
        end
      end
      if (ov) begin
        pcnt <= pcnt + PB'(1);
      end
    end
  end

  // Shared line memory address, one row minus one entry of delay.
  always_comb begin
    if (wc < WB'(2) || 32'(ptr) + 32'd2 >= 32'(wc)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + AB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (adv) begin
      ptr <= ptr_next;
    end
  end

  // Horizontal chain of cells.
  assign src = (inframe && colok) ? lab : '0;

  genvar c;
  generate
    for (c = 0; c < NC; c++) begin : g_h
      if (c == 0) begin : g_first
        assign pin[c] = '0;
      end else begin : g_rest
        assign pin[c] = pcell[c-1];
      end
      smd_hcell #(.LB(LB)) u_hcell (
        .clk  (clk),
        .adv  (adv),
        .pin  (pin[c]),
        .src  (src),
        .pout (pcell[c])
      );
    end
  endgenerate

  assign hsum = LB'(smd_merge(32'(pcell[sel]), 32'(src)));
  assign hm   = rowok ? hsum : '0;

  // Vertical chain of cells.
  assign vctl.adv   = adv;
  assign vctl.rd_ok = qv && (qrow != '0);

  generate
    for (c = 0; c < NC; c++) begin : g_v
      if (c == 0) begin : g_first
        assign vin[c] = hm;
      end else begin : g_rest
        assign vin[c] = vout[c-1];
      end
      smd_vcell #(.LB(LB), .DEPTH(DEPTH), .AB(AB)) u_vcell (
        .clk  (clk),
        .vctl (vctl),
        .ptr  (ptr),
        .vin  (vin[c]),
        .hm   (hm),
        .vout (vout[c])
      );
    end
  endgenerate

  // Result selection.
  always_comb begin
    if (mc == '0) begin
      res = inframe ? lab : '0;
    end else if (nosrc) begin
      res = '0;
    end else begin
      res = vout[sel];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && ov) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ov) begin
      out_label <= $signed(res);
      last      <= last_v;
    end
  end

endmodule

>>> sv/smd_checker.sv
module smd_checker #(
  parameter int LABEL_BITS = 17
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [LABEL_BITS-1:0] label,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [LABEL_BITS-1:0] out_label,
  input logic                         last,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [2:0]                   cfg_index,
  input logic [15:0]                  cfg_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_label) && $stable(last))
    else $error("stalled result changed");

  // The input side stalls only behind a waiting result.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Configuration writes are never refused.
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind segment_mask_dilation smd_checker #(.LABEL_BITS(LABEL_BITS)) u_smd_checker (.*);
